// File: src/bdeq_pkg.sv
// shared types and constants of the bounded double-ended queue
package bdeq_pkg;

  // ring storage geometry
  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  // transaction field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;

  // capacity register
  localparam int unsigned CAP_W   = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // width that holds both a capacity and an occupancy
  localparam int unsigned CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_LEFT  = 2'd0,
    OP_PUSH_RIGHT = 2'd1,
    OP_POP_LEFT   = 2'd2,
    OP_POP_RIGHT  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // memory access issued for one transaction
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

  // result of one transaction, before the memory read data joins it
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] value;
    logic              from_ram;
  } rsp_t;

endpackage

// File: src/bdeq_if.sv
// request and response channel interfaces of the double-ended queue
interface bdeq_req_if;
  import bdeq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface bdeq_rsp_if;
  import bdeq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] result_value;

  modport source (output valid, output status, output result_value, input ready);
  modport sink   (input valid, input status, input result_value, output ready);
endinterface

// File: src/bounded_double_ended_queue.sv
// Bounded double-ended queue held in a single-port ring memory. Each request
// transaction pushes or pops at the left or right end and yields exactly one
// response transaction: status done with the pushed or popped value, full for
// a refused push, or empty for a refused pop (value zero). A new request is
// taken every cycle while the output register is empty or being drained; its
// response appears in the output register in the next cycle, the popped word
// coming straight from the registered memory read port. The capacity register
// (reset 1024) is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while the queue is idle, which the block does not enforce. Values
// above the ring depth saturate to it, and zero refuses every push. After
// reset the queue is empty and ready at once; no clearing pass is needed.
module bounded_double_ended_queue import bdeq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  bdeq_req_if.sink         req_i,
  bdeq_rsp_if.source       rsp_o
);

  logic [CAP_W-1:0]  cap_q;
  logic              accept;
  ram_req_t          ram_req;
  rsp_t              rsp;
  logic [CNT_W-1:0]  occ;
  logic [DATA_W-1:0] rdata;
  logic              out_valid_q;
  status_e           status_q;
  logic [DATA_W-1:0] value_q;
  logic              from_ram_q;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // take a request when the output register is empty or frees up this cycle
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  bdeq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (accept),
    .op_i         (req_i.op),
    .push_value_i (req_i.push_value),
    .cap_i        (cap_q),
    .ram_req_o    (ram_req),
    .rsp_o        (rsp),
    .occ_o        (occ)
  );

  bdeq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_req.en),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (rdata)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= rsp.status;
      value_q    <= rsp.value;
      from_ram_q <= rsp.from_ram;
    end
  end

  // popped words come from the memory read register, held while stalled
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.result_value = from_ram_q ? rdata : value_q;

  // every accepted request shows a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.valid)
    else $error("response missing after accepted request");

  // occupancy never exceeds the ring depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(occ) <= CMP_W'(DEPTH))
    else $error("occupancy beyond ring depth");

  // a completed push grows the queue by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ram_req.en && ram_req.we) |=> (occ == $past(occ) + CNT_W'(1)))
    else $error("push did not grow occupancy");

  // refused requests carry a zero value
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_FULL || rsp_o.status == ST_EMPTY))
      |-> (rsp_o.result_value == '0))
    else $error("refused request with nonzero value");

endmodule

// File: src/bdeq_ram.sv
// generic single-port synchronous ram with registered read
module bdeq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or read one word per cycle when enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bdeq_ctrl.sv
// end pointers, occupancy and per-transaction decision of the queue
module bdeq_ctrl import bdeq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [DATA_W-1:0] push_value_i,
  input  logic [CAP_W-1:0]  cap_i,
  output ram_req_t          ram_req_o,
  output rsp_t              rsp_o,
  output logic [CNT_W-1:0]  occ_o
);

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
  localparam logic [CMP_W-1:0]  DEPTH_C  = CMP_W'(DEPTH);

  logic [ADDR_W-1:0] left_q, left_d;
  logic [ADDR_W-1:0] right_q, right_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [ADDR_W-1:0] left_dec, left_inc, right_dec, right_inc;
  logic [CMP_W-1:0]  cap_ext, cap_eff, occ_ext;
  logic              full, empty;

  // ring neighbors of both ends
  assign left_dec  = (left_q == '0) ? LAST_IDX : left_q - ADDR_W'(1);
  assign left_inc  = (left_q == LAST_IDX) ? '0 : left_q + ADDR_W'(1);
  assign right_dec = (right_q == '0) ? LAST_IDX : right_q - ADDR_W'(1);
  assign right_inc = (right_q == LAST_IDX) ? '0 : right_q + ADDR_W'(1);

  // capacity saturates at the ring depth
  assign cap_ext = CMP_W'(cap_i);
  assign cap_eff = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign occ_ext = CMP_W'(occ_q);
  assign full    = (occ_ext >= cap_eff);
  assign empty   = (occ_q == '0);

  // decide the transaction and the memory access
  always_comb begin
    left_d          = left_q;
    right_d         = right_q;
    occ_d           = occ_q;
    ram_req_o       = '0;
    ram_req_o.wdata = push_value_i;
    rsp_o.status    = ST_DONE;
    rsp_o.value     = '0;
    rsp_o.from_ram  = 1'b0;
    case (op_e'(op_i))
      OP_PUSH_LEFT, OP_PUSH_RIGHT: begin
        if (full) begin
          rsp_o.status = ST_FULL;
        end else begin
          ram_req_o.en = req_valid_i;
          ram_req_o.we = 1'b1;
          rsp_o.value  = push_value_i;
          occ_d        = occ_q + CNT_W'(1);
          if (op_e'(op_i) == OP_PUSH_LEFT) begin
            ram_req_o.addr = left_dec;
            left_d         = left_dec;
          end else begin
            ram_req_o.addr = right_q;
            right_d        = right_inc;
          end
        end
      end
      OP_POP_LEFT, OP_POP_RIGHT: begin
        if (empty) begin
          rsp_o.status = ST_EMPTY;
        end else begin
          ram_req_o.en   = req_valid_i;
          rsp_o.from_ram = 1'b1;
          occ_d          = occ_q - CNT_W'(1);
          if (op_e'(op_i) == OP_POP_LEFT) begin
            ram_req_o.addr = left_q;
            left_d         = left_inc;
          end else begin
            ram_req_o.addr = right_dec;
            right_d        = right_dec;
          end
        end
      end
      default: begin
        rsp_o.status = ST_DONE;
      end
    endcase
  end

  // pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      occ_q   <= '0;
    end else if (req_valid_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      occ_q   <= occ_d;
    end
  end

  assign occ_o = occ_q;

endmodule

// File: dv/tb_top.sv
// self-checking testbench of the bounded double-ended queue
module tb_top;
  import bdeq_pkg::*;

  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // one response as the queue should give it
  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] value;
  } deque_result_t;

  // deque predictor plus the responses still owed by the block
  class deque_scoreboard;
    logic [DATA_W-1:0] slots [DEPTH];
    int unsigned       left_slot;
    int unsigned       right_slot;
    int unsigned       fill;
    logic [CAP_W-1:0]  capacity;
    deque_result_t     awaited [$];
    int unsigned       errors;

    function new();
      left_slot  = 0;
      right_slot = 0;
      fill       = 0;
      capacity   = CAP_RESET;
      errors     = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // apply one accepted request and queue the response it must produce
    function void note_request(op_e op, logic [DATA_W-1:0] value);
      int unsigned   limit;
      deque_result_t r;
      limit    = (capacity > DEPTH) ? DEPTH : capacity;
      r.status = ST_DONE;
      r.value  = '0;
      case (op)
        OP_PUSH_LEFT, OP_PUSH_RIGHT: begin
          if (fill >= limit) begin
            r.status = ST_FULL;
          end else begin
            if (op == OP_PUSH_LEFT) begin
              left_slot = (left_slot + DEPTH - 1) % DEPTH;
              slots[left_slot] = value;
            end else begin
              slots[right_slot] = value;
              right_slot = (right_slot + 1) % DEPTH;
            end
            fill++;
            r.value = value;
          end
        end
        default: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            if (op == OP_POP_LEFT) begin
              r.value   = slots[left_slot];
              left_slot = (left_slot + 1) % DEPTH;
            end else begin
              right_slot = (right_slot + DEPTH - 1) % DEPTH;
              r.value    = slots[right_slot];
            end
            fill--;
          end
        end
      endcase
      awaited.insert(awaited.size(), r);
    endfunction

    // compare one accepted response with the oldest one owed
    function void check_response(logic [STAT_W-1:0] status, logic [DATA_W-1:0] value);
      deque_result_t r;
      if (awaited.size() == 0) begin
        errors++;
        $error("unexpected response: status %0d result_value %h", status, value);
        return;
      end
      r = awaited[0];
      awaited.delete(0);
      if (status !== r.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", r.status, status);
      end
      if (value !== r.value) begin
        errors++;
        $error("result_value: expected %h, actual %h", r.value, value);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  bdeq_req_if req_ch ();
  bdeq_rsp_if rsp_ch ();

  deque_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left    = 0;
  int unsigned cycles       = 0;

  // random phases: capacity, length and share of pushes
  int unsigned phase_cap  [NUM_PHASES] = '{3, 1, 2047, 0, 16, 1024, 2, 1023, 40, 2047};
  int unsigned phase_len  [NUM_PHASES] = '{40, 30, 1100, 20, 40, 50, 30, 40, 60, 40};
  int unsigned phase_push [NUM_PHASES] = '{60, 50, 98, 50, 55, 70, 50, 30, 65, 20};

  bounded_double_ended_queue uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // response side: check accepted transactions, then pick the next ready
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response(rsp_ch.status, rsp_ch.result_value);
      end
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // idle shares: sender light/receiver heavy, the reverse, then none
  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct = 14;
        recv_idle_pct = 63;
      end
      1: begin
        send_idle_pct = 63;
        recv_idle_pct = 14;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // offer one request until accepted, with random gaps in front
  task automatic send_request(input op_e op, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.push_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, value);
  endtask

  // capacity write once every owed response has come back
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(value);
  endtask

  // random requests under one capacity, optionally under a long receiver hold
  task automatic run_phase(input int unsigned cap, input int unsigned count,
                           input int unsigned push_pct, input bit with_hold);
    op_e op;
    write_capacity(CAP_W'(cap));
    if (with_hold) begin
      holds_asked++;
    end
    repeat (count) begin
      if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_RIGHT : OP_PUSH_LEFT;
      end else begin
        op = $urandom_range(1) ? OP_POP_RIGHT : OP_POP_LEFT;
      end
      send_request(op, $urandom());
    end
  endtask

  // stimulus
  initial begin
    int unsigned p;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_PUSH_LEFT;
    req_ch.push_value <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= CAP_RESET;
    rst_n             <= 1'b0;
    set_idling(0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pops on an empty queue at reset capacity
    send_request(OP_POP_LEFT, 32'h1234_5678);
    send_request(OP_POP_RIGHT, 32'hFFFF_FFFF);
    // extreme values at both ends, then drained back out
    send_request(OP_PUSH_LEFT, 32'h7FFF_FFFF);
    send_request(OP_PUSH_RIGHT, 32'h8000_0000);
    send_request(OP_PUSH_LEFT, 32'h0000_0000);
    send_request(OP_PUSH_RIGHT, 32'hFFFF_FFFF);
    send_request(OP_PUSH_LEFT, 32'h0000_0001);
    send_request(OP_POP_RIGHT, 32'h0);
    send_request(OP_POP_LEFT, 32'h0);
    send_request(OP_POP_LEFT, 32'h0);
    send_request(OP_POP_RIGHT, 32'h0);
    send_request(OP_POP_LEFT, 32'h0);
    send_request(OP_POP_RIGHT, 32'h0);
    // zero capacity refuses every push
    write_capacity(CAP_W'(0));
    send_request(OP_PUSH_LEFT, 32'hA5A5_A5A5);
    send_request(OP_PUSH_RIGHT, 32'h5A5A_5A5A);
    // fill a capacity of two
    write_capacity(CAP_W'(2));
    send_request(OP_PUSH_RIGHT, 32'h0000_00AA);
    send_request(OP_PUSH_LEFT, 32'h0000_00BB);
    send_request(OP_PUSH_RIGHT, 32'h0000_00CC);
    // capacity lowered below occupancy keeps entries, refuses pushes
    write_capacity(CAP_W'(1));
    send_request(OP_PUSH_LEFT, 32'h0000_00DD);
    send_request(OP_POP_RIGHT, 32'h0);
    send_request(OP_PUSH_RIGHT, 32'h0000_00EE);
    send_request(OP_POP_LEFT, 32'h0);
    send_request(OP_POP_LEFT, 32'h0);

    // random phases, saturating capacity and a long receiver hold among them
    for (p = 0; p < NUM_PHASES; p++) begin
      set_idling(p * 3 / NUM_PHASES);
      run_phase(phase_cap[p], phase_len[p], phase_push[p], p == 8);
    end

    // drain and settle
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/bdeq_pkg.sv
src/bdeq_if.sv
src/bdeq_ram.sv
src/bdeq_ctrl.sv
src/bounded_double_ended_queue.sv
dv/tb_top.sv
